>>> src/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the cache tag store simulator.
// ----------------------------------------------------------------------------
package sacl_pkg;
   localparam int MAX_SET_BITS_DEF = 8;
   localparam int MAX_WAYS_DEF = 8;
   localparam int ADDR_W = 64;
   localparam int MAX_OFFSET_BITS = 32;
   localparam int AGE_W = 3;
   localparam int CNT_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd2;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_STORE = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic hit;
      logic evicted;
      logic [CNT_W-1:0] hit_total;
      logic [CNT_W-1:0] miss_total;
      logic [CNT_W-1:0] evict_total;
   } rsp_type;
endpackage

>>> src/sacl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if
// Valid/ready channels of the request and response streams.
// ----------------------------------------------------------------------------
interface sacl_req_if;
   logic valid;
   logic ready;
   logic [1:0] opcode;
   logic [sacl_pkg::ADDR_W-1:0] address;
   modport source (output valid, opcode, address, input ready);
   modport sink (input valid, opcode, address, output ready);
endinterface

interface sacl_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic evicted;
   logic [sacl_pkg::CNT_W-1:0] hit_total;
   logic [sacl_pkg::CNT_W-1:0] miss_total;
   logic [sacl_pkg::CNT_W-1:0] evict_total;
   modport source (output valid, hit, evicted, hit_total, miss_total, evict_total,
                   input ready);
   modport sink (input valid, hit, evicted, hit_total, miss_total, evict_total,
                 output ready);
endinterface

>>> src/set_assoc_cache_lru_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag store of a set-associative cache with true LRU replacement.
// ----------------------------------------------------------------------------
// Requests (opcode, address) arrive on req; one response per request leaves
// on rsp with the hit and evicted flags of the first access and the
// saturating hit, miss and eviction totals. The user must write configuration
// through the csr port only while idle, which the block does not enforce.
// The whole set sits in one row of the line memory and one row of the
// valid memory. An access reads the set in one state and compares, updates
// and writes it back in the next; the result then enters the output
// register once it is free. A modify repeats the access on the same set;
// an unused opcode skips the access and goes straight to the output
// register.
// The next request is accepted once the result has moved into the output
// register, even while that register still waits for the receiver. If the
// receiver stalls with a result held and another finished, the block holds
// the second in its state until the register frees.
// Reset clears the counters, the control state and the valid memory row by
// row: a clearing pass over all 2^MAX_SET_BITS rows, during which no request
// is accepted.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
   input logic clock,
   input logic reset,
   sacl_req_if.sink req,
   sacl_rsp_if.source rsp,
   input logic csr_we,
   input logic [sacl_pkg::CSR_IDX_W-1:0] csr_idx,
   input logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int SETS = 1 << MAX_SET_BITS;
   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int AW = sacl_pkg::ADDR_W;
   localparam int AGE_W = sacl_pkg::AGE_W;
   localparam int CW = sacl_pkg::CNT_W;
   localparam logic [AGE_W-1:0] AGE_MAX = '1;
   localparam logic [CW-1:0] CNT_MAX = '1;
   localparam int ROW_W = MAX_WAYS * (AW + AGE_W);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_UPD = 3'd3;
   localparam logic [2:0] ST_HOLD = 3'd4;

   logic [3:0] set_bits_ff;
   logic [3:0] ways_used_ff;
   logic [5:0] offset_bits_ff;

   logic [2:0] state_ff, state_in;
   logic [SET_W-1:0] clr_ff;
   logic [1:0] op_ff;
   logic [AW-1:0] tag_ff;
   logic [SET_W-1:0] set_ff;
   logic second_ff;
   logic first_hit_ff, first_ev_ff;
   logic [CW-1:0] hits_ff, misses_ff, evicts_ff;
   logic ov_ff;
   sacl_pkg::rsp_type out_ff;

   logic [ROW_W-1:0] line_mem [SETS];
   logic [MAX_WAYS-1:0] valid_mem [SETS];
   logic [ROW_W-1:0] row_rd_ff;
   logic [MAX_WAYS-1:0] vld_rd_ff;

   logic [5:0] b_eff;
   logic [4:0] s_eff;
   logic [WAY_W:0] ways_eff;
   logic [AW-1:0] tag_calc;
   logic [SET_W-1:0] set_calc;
   logic [AW-1:0] shifted;
   logic [AW-1:0] set_mask;

   always_comb begin
      b_eff = (offset_bits_ff > 6'(sacl_pkg::MAX_OFFSET_BITS))
            ? 6'(sacl_pkg::MAX_OFFSET_BITS) : offset_bits_ff;
      s_eff = ({1'b0, set_bits_ff} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
            : {1'b0, set_bits_ff};
      if (ways_used_ff == 4'd0) begin
         ways_eff = (WAY_W + 1)'(1);
      end else if (32'(ways_used_ff) > MAX_WAYS) begin
         ways_eff = (WAY_W + 1)'(MAX_WAYS);
      end else begin
         ways_eff = (WAY_W + 1)'(ways_used_ff);
      end
      shifted = req.address >> b_eff;
      set_mask = ~({AW{1'b1}} << s_eff);
      set_calc = SET_W'(shifted & set_mask);
      tag_calc = shifted >> s_eff;
   end

   logic hit_any, empty_any;
   logic [WAY_W-1:0] hit_way, empty_way, vic_way, sel_way;
   logic [AGE_W-1:0] vic_age, limit;
   logic [AW-1:0] way_tag [MAX_WAYS];
   logic [AGE_W-1:0] way_age [MAX_WAYS];
   logic [MAX_WAYS-1:0] used;
   logic [ROW_W-1:0] row_new;
   logic [MAX_WAYS-1:0] vld_new;
   logic limit_all;

   always_comb begin
      hit_any = 1'b0;
      empty_any = 1'b0;
      hit_way = '0;
      empty_way = '0;
      vic_way = '0;
      vic_age = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         way_tag[i] = row_rd_ff[i*(AW+AGE_W) +: AW];
         way_age[i] = row_rd_ff[i*(AW+AGE_W)+AW +: AGE_W];
         used[i] = (i < 32'(ways_eff));
      end
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (used[i] && vld_rd_ff[i] && way_tag[i] == tag_ff) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (used[i] && !vld_rd_ff[i]) begin
            empty_any = 1'b1;
            empty_way = WAY_W'(i);
         end
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (used[i] && vld_rd_ff[i] && way_age[i] > vic_age) begin
            vic_age = way_age[i];
            vic_way = WAY_W'(i);
         end
      end
      sel_way = hit_any ? hit_way : (empty_any ? empty_way : vic_way);
      limit = way_age[hit_way];
      limit_all = !hit_any;
      row_new = row_rd_ff;
      vld_new = vld_rd_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAY_W'(i) == sel_way) begin
            row_new[i*(AW+AGE_W) +: AW] = tag_ff;
            row_new[i*(AW+AGE_W)+AW +: AGE_W] = '0;
            vld_new[i] = 1'b1;
         end else if (used[i] && vld_rd_ff[i] && (limit_all || way_age[i] < limit)
                      && way_age[i] != AGE_MAX) begin
            row_new[i*(AW+AGE_W)+AW +: AGE_W] = way_age[i] + AGE_W'(1);
         end
      end
   end

   logic accept, rsp_free, do_upd;
   assign rsp_free = !ov_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;
   assign do_upd = (state_ff == ST_UPD);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == SET_W'(SETS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               state_in = (req.opcode == sacl_pkg::OP_NONE) ? ST_HOLD : ST_READ;
            end
         end
         ST_READ: state_in = ST_UPD;
         ST_UPD: begin
            if (op_ff == sacl_pkg::OP_MODIFY && !second_ff) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_upd) begin
         line_mem[set_ff] <= row_new;
      end
      row_rd_ff <= line_mem[set_ff];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         valid_mem[clr_ff] <= '0;
      end else if (do_upd) begin
         valid_mem[set_ff] <= vld_new;
      end
      vld_rd_ff <= valid_mem[set_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req.opcode;
         tag_ff <= tag_calc;
         set_ff <= set_calc;
      end
      if (do_upd && !second_ff) begin
         first_hit_ff <= hit_any;
         first_ev_ff <= !hit_any && !empty_any;
      end
      if (state_ff == ST_HOLD && rsp_free) begin
         out_ff.hit <= (op_ff == sacl_pkg::OP_NONE) ? 1'b0 : first_hit_ff;
         out_ff.evicted <= (op_ff == sacl_pkg::OP_NONE) ? 1'b0 : first_ev_ff;
         out_ff.hit_total <= hits_ff;
         out_ff.miss_total <= misses_ff;
         out_ff.evict_total <= evicts_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         second_ff <= 1'b0;
         ov_ff <= 1'b0;
         hits_ff <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
         set_bits_ff <= 4'd0;
         ways_used_ff <= 4'd1;
         offset_bits_ff <= 6'd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + SET_W'(1);
         if (accept) second_ff <= 1'b0;
         else if (do_upd) second_ff <= 1'b1;
         if (do_upd) begin
            if (hit_any) begin
               if (hits_ff != CNT_MAX) hits_ff <= hits_ff + CW'(1);
            end else begin
               if (misses_ff != CNT_MAX) misses_ff <= misses_ff + CW'(1);
               if (!empty_any && evicts_ff != CNT_MAX) evicts_ff <= evicts_ff + CW'(1);
            end
         end
         if (state_ff == ST_HOLD && rsp_free) ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_idx)
               sacl_pkg::CSR_SET_BITS: set_bits_ff <= csr_wdata[3:0];
               sacl_pkg::CSR_WAYS_USED: ways_used_ff <= csr_wdata[3:0];
               sacl_pkg::CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp.valid = ov_ff;
   assign rsp.hit = out_ff.hit;
   assign rsp.evicted = out_ff.evicted;
   assign rsp.hit_total = out_ff.hit_total;
   assign rsp.miss_total = out_ff.miss_total;
   assign rsp.evict_total = out_ff.evict_total;

   a_second_hits: assert property (@(posedge clock) disable iff (reset)
      do_upd && second_ff |-> hit_any)
      else $error("second access of a modify missed");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req.ready)
      else $error("request taken during clearing pass");
   a_upd_after_read: assert property (@(posedge clock) disable iff (reset)
      do_upd |-> $past(state_ff) == ST_READ)
      else $error("update without read");
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(do_upd && hit_any) && $past(hits_ff) != CNT_MAX
      |-> hits_ff == $past(hits_ff) + CW'(1))
      else $error("hit count not advanced");
endmodule
